// ===== rtl/wto_pkg.sv =====
// Shared constants and types for the wavetable oscillator.
// No dependencies.
package wto_pkg;

  localparam int unsigned TABLE_SIZE    = 1024;
  localparam int unsigned TABLE_COUNT   = 8;
  localparam int unsigned FRACTION_BITS = 16;

  localparam int unsigned IDX_W   = $clog2(TABLE_SIZE);
  localparam int unsigned SEL_W   = $clog2(TABLE_COUNT);
  localparam int unsigned ADDR_W  = IDX_W + SEL_W;
  localparam int unsigned PHASE_W = IDX_W + FRACTION_BITS;
  localparam int unsigned DEPTH   = TABLE_SIZE * TABLE_COUNT;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned RATE_W   = 32;
  localparam int unsigned MIX_W    = 24;
  localparam int unsigned GAIN_SH  = FRACTION_BITS + 14;
  localparam int unsigned DATA_W   = 88;

  // input kind carried in tuser
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_WAVE_SELECT = 2'd0;
  localparam logic [1:0] CFG_OCTAVE_CODE = 2'd1;
  localparam logic [1:0] CFG_FINE_TUNE   = 2'd2;
  localparam logic [1:0] CFG_OUT_GAIN    = 2'd3;

  localparam logic [2:0] OCTAVE_MAX = 3'd5;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

endpackage

// ===== rtl/wavetable_oscillator_interp.sv =====
// Wavetable oscillator with linear interpolation: table memory, phase accumulator,
// interpolation, gain, mix and saturation.
// Depends on wto_pkg.

// A load word (tuser = 0) writes one table entry in the cycle it is accepted,
// so loads stream at one word per cycle while the block is idle. A sample word
// (tuser = 1) occupies the block from acceptance until the input is ready again:
// the table memory has one read port, so entry i and entry i+1 are read in
// successive cycles, then the interpolation multiply and the gain multiply are
// each registered, and the final step rounds, mixes, saturates and loads the
// output register. That final step waits while the output register still holds
// an untaken word. The tables are not cleared after reset; reading an entry
// that was never loaded gives an undefined sample. Configuration writes are
// always ready and must only be issued while the block is idle.
module wavetable_oscillator_interp
  import wto_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // stream input
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // table_number[2:0], table_index[12:3], table_value[28:13], rate_in[60:29],
  // mix_in[84:61], zero pad[87:85]
  input  logic [DATA_W-1:0] s_axis_tdata,
  // op[0]
  input  logic              s_axis_tuser,
  // stream output
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // sample_out[23:0]
  output logic [MIX_W-1:0]  m_axis_tdata,
  // configuration writes
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_B,
    S_MUL1,
    S_MUL2,
    S_OUT
  } state_e;

  state_e state_q;

  // configuration
  logic [SEL_W-1:0] wave_select_q;
  logic [2:0]       octave_code_q;
  logic [15:0]      fine_tune_q;
  logic [15:0]      out_gain_q;

  logic [PHASE_W-1:0] phase_q;

  // per-sample working registers
  logic signed [RATE_W-1:0] rate_q;
  logic signed [MIX_W-1:0]  mix_q;
  logic [FRACTION_BITS-1:0] frac_q;
  logic [IDX_W-1:0]         idx_q;
  sample_t                  a_q;
  logic signed [RATE_W+16:0] prod_q;
  logic signed [33:0]       interp_q;
  logic signed [50:0]       scaled_q;
  logic [MIX_W-1:0]         out_data_q;
  logic                     out_valid_q;

  // table memory
  sample_t             mem_q [DEPTH];
  sample_t             rd_data_q;
  logic [ADDR_W-1:0]   rd_addr;
  logic [ADDR_W-1:0]   wr_addr;
  logic                wr_en;

  logic in_accept;
  logic out_free;

  // input field views
  logic [SEL_W-1:0]  in_table_number;
  logic [IDX_W-1:0]  in_table_index;
  sample_t           in_table_value;
  logic signed [RATE_W-1:0] in_rate;
  logic signed [MIX_W-1:0]  in_mix;

  assign in_table_number = s_axis_tdata[2:0];
  assign in_table_index  = s_axis_tdata[12:3];
  assign in_table_value  = s_axis_tdata[28:13];
  assign in_rate         = s_axis_tdata[60:29];
  assign in_mix          = s_axis_tdata[84:61];

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // a load and a read can touch the same entry in one cycle: the read port reads
  // in every state, idle included, and then returns the entry's old value
  assign wr_en   = in_accept && (s_axis_tuser == OP_LOAD);
  assign wr_addr = {in_table_number, in_table_index};
  assign rd_addr = (state_q == S_IDLE) ? {wave_select_q, phase_q[PHASE_W-1 -: IDX_W]}
                                       : {wave_select_q, idx_q + IDX_W'(1)};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= in_table_value;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  // datapath
  logic [2:0]                oct;
  logic signed [RATE_W+21:0] step_wide;
  logic signed [RATE_W+21:0] step_shr;
  logic [PHASE_W-1:0]        phase_d;
  logic signed [16:0]        diff;
  logic signed [33:0]        interp_d;
  logic signed [50:0]        rounded;
  logic signed [50:0]        shifted;
  logic signed [25:0]        sum;
  logic [MIX_W-1:0]          sat;

  always_comb begin
    oct       = (octave_code_q > OCTAVE_MAX) ? OCTAVE_MAX : octave_code_q;
    step_wide = (RATE_W+22)'(prod_q) <<< oct;
    step_shr  = step_wide >>> 17;
    phase_d   = phase_q + step_shr[PHASE_W-1:0];

    diff     = 17'(rd_data_q) - 17'(a_q);
    interp_d = (34'(a_q) <<< FRACTION_BITS) + diff * $signed({1'b0, frac_q});

    rounded = scaled_q + (51'sd1 <<< (GAIN_SH - 1));
    shifted = rounded >>> GAIN_SH;
    sum     = 26'(mix_q) + shifted[25:0];
    if (sum[25:23] == 3'b000 || sum[25:23] == 3'b111) begin
      sat = sum[MIX_W-1:0];
    end else if (sum[25]) begin
      sat = {1'b1, {(MIX_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(MIX_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      phase_q       <= '0;
      out_valid_q   <= 1'b0;
      wave_select_q <= '0;
      octave_code_q <= 3'd1;
      fine_tune_q   <= 16'd32768;
      out_gain_q    <= 16'd16384;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_WAVE_SELECT: wave_select_q <= cfg_data_i[SEL_W-1:0];
          CFG_OCTAVE_CODE: octave_code_q <= cfg_data_i[2:0];
          CFG_FINE_TUNE:   fine_tune_q   <= cfg_data_i;
          CFG_OUT_GAIN:    out_gain_q    <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_accept && s_axis_tuser == OP_SAMPLE) begin
            state_q <= S_RD_B;
          end
        end
        S_RD_B: begin
          state_q <= S_MUL1;
        end
        S_MUL1: begin
          phase_q <= phase_d;
          state_q <= S_MUL2;
        end
        S_MUL2: begin
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      rate_q <= in_rate;
      mix_q  <= in_mix;
      frac_q <= phase_q[FRACTION_BITS-1:0];
      idx_q  <= phase_q[PHASE_W-1 -: IDX_W];
    end
    if (state_q == S_RD_B) begin
      a_q    <= rd_data_q;
      prod_q <= rate_q * $signed({1'b0, fine_tune_q});
    end
    if (state_q == S_MUL1) begin
      interp_q <= interp_d;
    end
    if (state_q == S_MUL2) begin
      scaled_q <= interp_q * $signed({1'b0, out_gain_q});
    end
    if (state_q == S_OUT && out_free) begin
      out_data_q <= sat;
    end
  end

  // a new output word only comes from the final step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("output word not produced by final step");

  // phase only advances once per sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(phase_q) |-> $past(state_q == S_MUL1))
    else $error("phase changed outside update step");

  // interlock: a waiting output word stalls the final step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_valid_q && !m_axis_tready) |=> (state_q == S_OUT))
    else $error("output word overwritten while stalled");

  // a load never starts the sample sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && s_axis_tuser == OP_LOAD) |=> (state_q == S_IDLE))
    else $error("load word left idle state");

endmodule
